// ===== rtl/core/linear_phase_ramp_rotator_defines.svh =====
// assertion macros for the linear phase ramp rotator
`ifndef LINEAR_PHASE_RAMP_ROTATOR_DEFINES_SVH
`define LINEAR_PHASE_RAMP_ROTATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define LPRR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define LPRR_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LPRR_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPRR_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/core/lprr_pkg.sv =====
package lprr_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_BINS_DEF = 4096;
    localparam int STEP_WIDTH   = 32;
    localparam int LEN_WIDTH    = 13;
    localparam int ROM_DEPTH    = 1024;
    localparam int ROM_AW       = 10;
    localparam int ROM_W        = 16;
    localparam int PHASE_TOP_W  = ROM_AW + 2;
    localparam int MID_DEPTH    = 4;
    localparam int OUT_DEPTH    = 8;
    localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // register indexes, selected by paddr[2]
    localparam logic REG_PHASE_STEP  = 1'b0;
    localparam logic REG_LINE_LENGTH = 1'b1;

    localparam logic [LEN_WIDTH-1:0] LINE_LENGTH_RESET = 13'd4096;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_i;
        logic signed [SAMPLE_WIDTH-1:0] sample_q;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] rotated_i;
        logic signed [SAMPLE_WIDTH-1:0] rotated_q;
        logic                           end_of_line;
    } result_t;

    // classified bin handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_i;
        logic signed [SAMPLE_WIDTH-1:0] sample_q;
        logic [PHASE_TOP_W-1:0]         phase;
        logic                           last;
    } mid_item_t;

    typedef struct packed {
        logic [STEP_WIDTH-1:0] phase_step;
        logic [LEN_WIDTH-1:0]  line_length;
        logic                  restart;
    } cfg_t;

    typedef struct packed {
        logic last;
        logic line_start;
    } front_status_t;

    typedef logic [ROM_W-1:0] sine_rom_t [ROM_DEPTH];

    // quarter-wave sine, centre of each cell, integer taylor series in q30
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        scaled;
        for (int n = 0; n < ROM_DEPTH; n++)
        begin
            x    = (PI_Q30 * 64'(2 * n + 1)) >> 12;
            x2   = (x * x) >> 30;
            term = x;
            acc  = $signed(x);
            for (int k = 1; k <= 8; k++)
            begin
                term = (term * x2) >> 30;
                unique case (k)
                    1:       term = term / 64'd6;
                    2:       term = term / 64'd20;
                    3:       term = term / 64'd42;
                    4:       term = term / 64'd72;
                    5:       term = term / 64'd110;
                    6:       term = term / 64'd156;
                    7:       term = term / 64'd210;
                    default: term = term / 64'd272;
                endcase
                if (k[0])
                    acc = acc - $signed(term);
                else
                    acc = acc + $signed(term);
            end
            if (acc < 0)
                acc = 0;
            scaled = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
            rom[n] = scaled[ROM_W-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/core/lprr_fifo.sv =====
module lprr_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_ok;
    logic             rd_ok;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem[rd_ptr_reg];
    assign wr_ok   = wr_en && !full;
    assign rd_ok   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_ok)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_ok)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_ok && !rd_ok)
            count_next = count_reg + 1'b1;
        else if (rd_ok && !wr_ok)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/core/lprr_front.sv =====
module lprr_front #(
    parameter int MAX_BINS = lprr_pkg::MAX_BINS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lprr_pkg::cfg_t          cfg,
    input  logic                    push,
    input  lprr_pkg::sample_t       sample,
    output logic                    full,
    input  logic                    mid_full,
    output logic                    mid_push,
    output lprr_pkg::mid_item_t     mid_item,
    output lprr_pkg::front_status_t status
);

    localparam int LEN_W = $clog2(MAX_BINS + 1);
    localparam int LW1   = LEN_W + 1;
    localparam int CNT_W = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
    localparam int SW    = lprr_pkg::STEP_WIDTH;
    localparam int RESET_LEN = (MAX_BINS < 4096) ? MAX_BINS : 4096;

    logic             restart_pend_reg, restart_pend_next;
    logic [LEN_W-1:0] eff_len_reg, eff_len_next;
    logic [SW-1:0]    start_phase_reg, start_phase_next;
    logic [SW-1:0]    phase_accum_reg, phase_accum_next;
    logic [CNT_W-1:0] bin_count_reg, bin_count_next;
    logic [LEN_W-1:0] eff_len_cfg;
    logic [SW-1:0]    half_ext;
    logic             accept;
    logic             last;

    // clamp the line length to [2, MAX_BINS]
    always_comb
    begin
        if (cfg.line_length < lprr_pkg::LEN_WIDTH'(2))
            eff_len_cfg = LEN_W'(2);
        else if (32'(cfg.line_length) > 32'(MAX_BINS))
            eff_len_cfg = LEN_W'(MAX_BINS);
        else
            eff_len_cfg = LEN_W'(cfg.line_length);
    end

    assign half_ext = SW'(eff_len_cfg >> 1);
    assign full     = mid_full || restart_pend_reg;
    assign accept   = push && !full;
    assign last     = (LW1'(bin_count_reg) + 1'b1) >= LW1'(eff_len_reg);

    assign mid_push          = accept;
    assign mid_item.sample_i = sample.sample_i;
    assign mid_item.sample_q = sample.sample_q;
    assign mid_item.phase    = phase_accum_reg[SW-1 -: lprr_pkg::PHASE_TOP_W];
    assign mid_item.last     = last;

    assign status.last       = last;
    assign status.line_start = (bin_count_reg == '0);

    always_comb
    begin
        restart_pend_next = cfg.restart;
        eff_len_next      = eff_len_reg;
        start_phase_next  = start_phase_reg;
        phase_accum_next  = phase_accum_reg;
        bin_count_next    = bin_count_reg;
        priority if (restart_pend_reg)
        begin
            // new settings: recompute the start phase of a line
            eff_len_next     = eff_len_cfg;
            start_phase_next = '0 - (half_ext * cfg.phase_step);
            phase_accum_next = '0 - (half_ext * cfg.phase_step);
            bin_count_next   = '0;
        end
        else if (accept && last)
        begin
            phase_accum_next = start_phase_reg;
            bin_count_next   = '0;
        end
        else if (accept)
        begin
            phase_accum_next = phase_accum_reg + cfg.phase_step;
            bin_count_next   = bin_count_reg + 1'b1;
        end
        else
        begin
            // idle: hold the line position
            bin_count_next = bin_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_pend_reg <= 1'b0;
            eff_len_reg      <= LEN_W'(RESET_LEN);
            start_phase_reg  <= '0;
            phase_accum_reg  <= '0;
            bin_count_reg    <= '0;
        end
        else
        begin
            restart_pend_reg <= restart_pend_next;
            eff_len_reg      <= eff_len_next;
            start_phase_reg  <= start_phase_next;
            phase_accum_reg  <= phase_accum_next;
            bin_count_reg    <= bin_count_next;
        end
    end

endmodule

// ===== rtl/core/lprr_back.sv =====
module lprr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            mid_empty,
    input  lprr_pkg::mid_item_t             mid_item,
    output logic                            mid_pop,
    input  logic [lprr_pkg::OUT_CNT_W-1:0]  out_count,
    output logic                            out_push,
    output lprr_pkg::result_t               out_item
);

    localparam int SW   = lprr_pkg::SAMPLE_WIDTH;
    localparam int RW   = lprr_pkg::ROM_W;
    localparam int PW   = SW + RW;
    localparam int SUMW = PW + 1;
    localparam int SHW  = SUMW - 14;
    localparam logic signed [SHW-1:0] SAT_HI = SHW'((1 << (SW - 1)) - 1);
    localparam logic signed [SHW-1:0] SAT_LO = SHW'(-(1 << (SW - 1)));

    // add half an lsb, floor, clamp
    function automatic logic signed [SW-1:0] round_sat(input logic signed [SUMW-1:0] v);
        logic signed [SUMW:0]  biased;
        logic signed [SHW-1:0] shifted;
        biased  = $signed({v[SUMW-1], v}) + $signed((SUMW + 1)'(16384));
        shifted = $signed(biased[SUMW:15]);
        if (shifted > SAT_HI)
            return SW'(SAT_HI);
        else if (shifted < SAT_LO)
            return SW'(SAT_LO);
        else
            return SW'(shifted);
    endfunction

    logic                          take;
    logic [lprr_pkg::OUT_CNT_W:0]  used;
    logic [1:0]                    quad;
    logic [lprr_pkg::ROM_AW-1:0]   idx;
    logic signed [RW-1:0]          rom_a;
    logic signed [RW-1:0]          rom_b;
    logic signed [RW-1:0]          sin_sel;
    logic signed [RW-1:0]          cos_sel;

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 last1_reg, last2_reg, last3_reg;
    logic signed [SW-1:0] xi1_reg, xq1_reg;
    logic signed [RW-1:0] s1_reg, c1_reg;
    logic signed [PW-1:0] p_ic_reg, p_qs_reg, p_is_reg, p_qc_reg;
    logic signed [SW-1:0] ri3_reg, rq3_reg;
    logic signed [SUMW-1:0] sum_i, sum_q;

    // pop only with room reserved downstream for every stage in flight
    assign used    = (lprr_pkg::OUT_CNT_W + 1)'(out_count)
                   + (lprr_pkg::OUT_CNT_W + 1)'(v1_reg)
                   + (lprr_pkg::OUT_CNT_W + 1)'(v2_reg)
                   + (lprr_pkg::OUT_CNT_W + 1)'(v3_reg);
    assign take    = !mid_empty && (used < (lprr_pkg::OUT_CNT_W + 1)'(lprr_pkg::OUT_DEPTH));
    assign mid_pop = take;

    assign quad  = mid_item.phase[lprr_pkg::PHASE_TOP_W-1 -: 2];
    assign idx   = mid_item.phase[lprr_pkg::ROM_AW-1:0];
    assign rom_a = $signed(lprr_pkg::SINE_ROM[idx]);
    assign rom_b = $signed(lprr_pkg::SINE_ROM[~idx]);

    always_comb
    begin
        unique case (quad)
            2'd0:
            begin
                sin_sel = rom_a;
                cos_sel = rom_b;
            end
            2'd1:
            begin
                sin_sel = rom_b;
                cos_sel = -rom_a;
            end
            2'd2:
            begin
                sin_sel = -rom_a;
                cos_sel = -rom_b;
            end
            default:
            begin
                sin_sel = -rom_b;
                cos_sel = rom_a;
            end
        endcase
    end

    assign sum_i = SUMW'(p_ic_reg) - SUMW'(p_qs_reg);
    assign sum_q = SUMW'(p_is_reg) + SUMW'(p_qc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // lookup
        xi1_reg   <= mid_item.sample_i;
        xq1_reg   <= mid_item.sample_q;
        s1_reg    <= sin_sel;
        c1_reg    <= cos_sel;
        last1_reg <= mid_item.last;
        // products
        p_ic_reg  <= xi1_reg * c1_reg;
        p_qs_reg  <= xq1_reg * s1_reg;
        p_is_reg  <= xi1_reg * s1_reg;
        p_qc_reg  <= xq1_reg * c1_reg;
        last2_reg <= last1_reg;
        // sums, rounding and saturation
        ri3_reg   <= round_sat(sum_i);
        rq3_reg   <= round_sat(sum_q);
        last3_reg <= last2_reg;
    end

    assign out_push             = v3_reg;
    assign out_item.rotated_i   = ri3_reg;
    assign out_item.rotated_q   = rq3_reg;
    assign out_item.end_of_line = last3_reg;

endmodule

// ===== rtl/core/linear_phase_ramp_rotator.sv =====
// linear phase ramp rotator: rotates bin k of each spectrum line by (k - floor(N/2)) * step,
// where phase_step is a signed fraction of a turn in units of 2^-32 and N is line_length
// clamped to [2, MAX_BINS]. one transaction is accepted per clock while full is low and one
// result per clock can be taken; the phase accumulator sets that rate. a result passes
// through the small queue, the lookup, multiply and round stages and the result queue before it
// appears on the result side. sine and cosine come from a 1024-entry quarter-wave table on
// the top 12 phase bits; products are rounded half-up and saturated.
// end_of_line marks bin N-1, after which the phase restarts. any register write restarts the
// line and holds full high for one clock while the start phase is recomputed; write registers
// only while no transaction is in flight
`include "linear_phase_ramp_rotator_defines.svh"

module linear_phase_ramp_rotator #(
    parameter int MAX_BINS = lprr_pkg::MAX_BINS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // bin input
    input  logic              push,
    output logic              full,
    input  lprr_pkg::sample_t sample,
    // result output
    output logic              empty,
    input  logic              pop,
    output lprr_pkg::result_t result,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int MID_CNT_W = $clog2(lprr_pkg::MID_DEPTH + 1);
    localparam logic [MID_CNT_W-1:0] MID_FILL_MAX = MID_CNT_W'(lprr_pkg::MID_DEPTH);

    logic [lprr_pkg::STEP_WIDTH-1:0] phase_step_reg, phase_step_next;
    logic [lprr_pkg::LEN_WIDTH-1:0]  line_length_reg, line_length_next;
    logic                            cfg_wr;
    logic                            reg_sel;

    lprr_pkg::cfg_t                  cfg;
    lprr_pkg::front_status_t         front_status;
    lprr_pkg::mid_item_t             mid_in;
    lprr_pkg::mid_item_t             mid_out;
    logic [$bits(lprr_pkg::mid_item_t)-1:0] mid_rd_vec;
    logic                            mid_push;
    logic                            mid_full;
    logic                            mid_pop;
    logic                            mid_empty;
    logic [MID_CNT_W-1:0]            mid_count;

    lprr_pkg::result_t               out_in;
    logic [$bits(lprr_pkg::result_t)-1:0] out_rd_vec;
    logic                            out_push;
    logic                            out_full;
    logic [lprr_pkg::OUT_CNT_W-1:0]  out_count;

    logic                            last_taken;
    logic                            line_start;

    // register port, writes land on the access phase
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        phase_step_next  = phase_step_reg;
        line_length_next = line_length_reg;
        if (cfg_wr)
        begin
            unique case (reg_sel)
                lprr_pkg::REG_PHASE_STEP:  phase_step_next  = pwdata;
                default:                   line_length_next = pwdata[lprr_pkg::LEN_WIDTH-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            lprr_pkg::REG_LINE_LENGTH: prdata = 32'(line_length_reg);
            default:                   prdata = phase_step_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= '0;
            line_length_reg <= lprr_pkg::LINE_LENGTH_RESET;
        end
        else
        begin
            phase_step_reg  <= phase_step_next;
            line_length_reg <= line_length_next;
        end
    end

    // every write to a register restarts the line
    assign cfg.phase_step  = phase_step_reg;
    assign cfg.line_length = line_length_reg;
    assign cfg.restart     = cfg_wr;

    // front: phase accumulator and bin counter, tags each bin
    lprr_front #(
        .MAX_BINS (MAX_BINS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .push     (push),
        .sample   (sample),
        .full     (full),
        .mid_full (mid_full),
        .mid_push (mid_push),
        .mid_item (mid_in),
        .status   (front_status)
    );

    // queue between front and back
    lprr_fifo #(
        .WIDTH ($bits(lprr_pkg::mid_item_t)),
        .DEPTH (lprr_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (mid_in),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_rd_vec),
        .empty   (mid_empty),
        .count   (mid_count)
    );

    assign mid_out = lprr_pkg::mid_item_t'(mid_rd_vec);

    // back: table lookup, complex multiply, round and saturate
    lprr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_item  (mid_out),
        .mid_pop   (mid_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_item  (out_in)
    );

    // result queue, the back never pushes without reserved room
    lprr_fifo #(
        .WIDTH ($bits(lprr_pkg::result_t)),
        .DEPTH (lprr_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_in),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_rd_vec),
        .empty   (empty),
        .count   (out_count)
    );

    assign result = lprr_pkg::result_t'(out_rd_vec);

    // last bin of a line taken, and the counter back at the line start
    assign last_taken = push && !full && front_status.last;
    assign line_start = front_status.line_start;

    // checks
    `LPRR_NEVER(a_out_no_overflow, clk, rst_n, out_push && out_full, "result queue overflow")
    `LPRR_NEVER(a_mid_fill, clk, rst_n, mid_count > MID_FILL_MAX, "mid queue overfilled")
    `LPRR_ASSERT(a_restart_blocks_input, clk, rst_n, cfg_wr |=> full, "input open during restart")
    `LPRR_ASSERT(a_line_wraps, clk, rst_n, last_taken |=> line_start, "no wrap after last bin")

endmodule
